// ===== src/motion_heading_steer_decider_macros.svh =====
// Assertion macros shared by the heading steer decider modules.
`ifndef MOTION_HEADING_STEER_DECIDER_MACROS_SVH
`define MOTION_HEADING_STEER_DECIDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mhsd_pkg.sv =====
// Shared constants, types and functions of the heading steer decider.
package mhsd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    // Vector width: sample, 2^14 scale, and headroom for CORDIC gain and negation.
    localparam int XY_W         = SAMPLE_BITS + 14 + 3;
    // Angle in Q16 degrees; covers -100 .. 360 degrees with margin.
    localparam int Z_W          = 27;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CMP_W        = 17;

    localparam logic [1:0] CMD_STOP    = 2'd0;
    localparam logic [1:0] CMD_FORWARD = 2'd1;
    localparam logic [1:0] CMD_LEFT    = 2'd2;
    localparam logic [1:0] CMD_RIGHT   = 2'd3;

    localparam logic REG_TURN_TOL  = 1'b0;
    localparam logic REG_STILL_THR = 1'b1;

    typedef struct packed {
        logic                          still;
        logic signed [SAMPLE_BITS-1:0] mag_x;
        logic signed [SAMPLE_BITS-1:0] mag_y;
        logic signed [9:0]             remote;
    } t_job;

    // Remote angle (360*(b-33))/222 truncated toward zero. The magnitude
    // 180*|n|/111 is found by a reciprocal multiply, exact for |n| <= 222.
    function automatic logic signed [9:0] remote_of(input logic [7:0] b);
        logic signed [8:0] n;
        logic [7:0]        mag;
        logic [15:0]       v;
        logic [31:0]       p;
        logic [9:0]        q;
        n   = $signed({1'b0, b}) - 9'sd33;
        mag = (n < 0) ? 8'(-n) : n[7:0];
        v   = 16'(16'(mag) * 16'd180);
        p   = 32'(v) * 32'd37787;
        q   = 10'(p >> 22);
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    // atan(2^-i) in Q16 degrees.
    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/mhsd_front.sv =====
// Front end: takes input beats, decodes the remote angle and tracks z motion.
module mhsd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [55:0]          i_data,
    input  logic [15:0]          i_still_threshold,
    input  logic                 i_full,
    output logic                 o_push,
    output mhsd_pkg::t_job       o_job
);
    import mhsd_pkg::*;

    localparam int HIST_DEPTH = 3;

    logic signed [SAMPLE_BITS-1:0] r_hist [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] n_hist [HIST_DEPTH];
    logic [1:0]                    r_slot;
    logic [1:0]                    n_slot;
    logic [1:0]                    w_idx;
    logic signed [SAMPLE_BITS-1:0] w_az;
    logic signed [SAMPLE_BITS:0]   w_d01;
    logic signed [SAMPLE_BITS:0]   w_d12;
    logic [SAMPLE_BITS:0]          w_a01;
    logic [SAMPLE_BITS:0]          w_a12;
    logic                          w_still;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_az    = $signed(i_data[8 +: SAMPLE_BITS]);
    assign w_idx   = (r_slot < 2'd3) ? r_slot : 2'd0;

    always_comb begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            n_hist[k] = (w_idx == 2'(k)) ? w_az : r_hist[k];
        end
        n_slot = w_idx + 2'd1;
    end

    // Motion test on the history as it stands after this sample is written.
    assign w_d01 = {n_hist[0][SAMPLE_BITS-1], n_hist[0]} - {n_hist[1][SAMPLE_BITS-1], n_hist[1]};
    assign w_d12 = {n_hist[1][SAMPLE_BITS-1], n_hist[1]} - {n_hist[2][SAMPLE_BITS-1], n_hist[2]};
    assign w_a01 = (w_d01 < 0) ? unsigned'(-w_d01) : unsigned'(w_d01);
    assign w_a12 = (w_d12 < 0) ? unsigned'(-w_d12) : unsigned'(w_d12);
    assign w_still = (CMP_W'(w_a01) <= CMP_W'(i_still_threshold))
                  && (CMP_W'(w_a12) <= CMP_W'(i_still_threshold));

    always_comb begin
        o_job.still  = w_still;
        o_job.mag_x  = $signed(i_data[24 +: SAMPLE_BITS]);
        o_job.mag_y  = $signed(i_data[40 +: SAMPLE_BITS]);
        o_job.remote = remote_of(i_data[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_slot <= 2'd0;
        end else if (o_push) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= n_hist[k];
            end
            r_slot <= n_slot;
        end
    end

endmodule

// ===== src/mhsd_queue.sv =====
// Short job queue between the front end and the heading engine.
`include "motion_heading_steer_decider_macros.svh"
module mhsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mhsd_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output mhsd_pkg::t_job o_job,
    input  logic           i_pop
);
    import mhsd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `MHSD_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `MHSD_ASSERT_SAME(a_pop_nonempty, i_pop, r_count != '0, "pop from an empty queue")

endmodule

// ===== src/mhsd_back.sv =====
// Heading engine: iterative CORDIC, steering decision and output register.
`include "motion_heading_steer_decider_macros.svh"
module mhsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  mhsd_pkg::t_job i_job,
    output logic           o_pop,
    input  logic [7:0]     i_turn_tolerance,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [23:0]    o_data
);
    import mhsd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_ADJ  = 3'd2;
    localparam logic [2:0] ST_HEAD = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;

    localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] Z_FULL_TURN = Z_W'(360 * 65536);
    localparam logic signed [Z_W-1:0] Z_BIAS      = Z_W'(128);

    logic [2:0]              r_state, n_state;
    logic signed [XY_W-1:0]  r_x, n_x;
    logic signed [XY_W-1:0]  r_y, n_y;
    logic signed [Z_W-1:0]   r_z, n_z;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [8:0]              r_heading, n_heading;
    logic signed [9:0]       r_remote, n_remote;
    logic [1:0]              r_cmd, n_cmd;
    logic                    r_out_valid, n_out_valid;
    logic [23:0]             r_out_data, n_out_data;

    logic signed [XY_W-1:0]  w_x0, w_y0, w_xsh, w_ysh;
    logic signed [Z_W-1:0]   w_atan, w_zb;
    logic [Z_W-17:0]         w_deg;
    logic signed [10:0]      w_d;
    logic [9:0]              w_a, w_tol, w_lim;
    logic                    w_fwd, w_left;

    assign o_pop   = (r_state == ST_IDLE) && i_job_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    assign w_x0   = XY_W'(i_job.mag_x) <<< 14;
    assign w_y0   = XY_W'(i_job.mag_y) <<< 14;
    assign w_xsh  = r_x >>> r_step;
    assign w_ysh  = r_y >>> r_step;
    assign w_atan = $signed(Z_W'(atan_q16(5'(r_step))));
    assign w_zb   = r_z + Z_BIAS;
    assign w_deg  = unsigned'(r_z[Z_W-1:16]);

    assign w_d    = $signed({2'b00, r_heading}) - {r_remote[9], r_remote};
    assign w_a    = (w_d < 0) ? 10'(-w_d) : 10'(w_d);
    assign w_tol  = {2'b00, i_turn_tolerance};
    assign w_lim  = 10'd360 - w_tol;
    assign w_fwd  = (w_a < w_tol) || (w_a > w_lim) || (w_d == 11'sd0);
    assign w_left = ((w_d < 0) && (w_a < 10'd180)) || ((w_d > 0) && (w_a > 10'd180));

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_step      = r_step;
        n_heading   = r_heading;
        n_remote    = r_remote;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_remote = i_job.remote;
                    n_step   = '0;
                    if (i_job.still) begin
                        n_cmd     = CMD_STOP;
                        n_heading = 9'd0;
                        n_state   = ST_WAIT;
                    end else if (i_job.mag_y == '0) begin
                        n_heading = (i_job.mag_x < 0) ? 9'd180 : 9'd0;
                        n_state   = ST_DEC;
                    end else if (i_job.mag_x == '0) begin
                        n_heading = (i_job.mag_y > 0) ? 9'd90 : 9'd270;
                        n_state   = ST_DEC;
                    end else if (i_job.mag_x < 0) begin
                        n_x     = -w_x0;
                        n_y     = -w_y0;
                        n_z     = Z_HALF_TURN;
                        n_state = ST_ROT;
                    end else begin
                        n_x     = w_x0;
                        n_y     = w_y0;
                        n_z     = '0;
                        n_state = ST_ROT;
                    end
                end
            end
            ST_ROT: begin
                if (r_y >= 0) begin
                    n_x = r_x + w_ysh;
                    n_y = r_y - w_xsh;
                    n_z = r_z + w_atan;
                end else begin
                    n_x = r_x - w_ysh;
                    n_y = r_y + w_xsh;
                    n_z = r_z - w_atan;
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ: begin
                n_z     = (w_zb < 0) ? w_zb + Z_FULL_TURN : w_zb;
                n_state = ST_HEAD;
            end
            ST_HEAD: begin
                n_heading = (w_deg >= (Z_W-16)'(360)) ? 9'(w_deg - (Z_W-16)'(360))
                                                      : 9'(w_deg);
                n_state   = ST_DEC;
            end
            ST_DEC: begin
                priority if (w_fwd) begin
                    n_cmd = CMD_FORWARD;
                end else if (w_left) begin
                    n_cmd = CMD_LEFT;
                end else begin
                    n_cmd = CMD_RIGHT;
                end
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_remote, r_heading, r_cmd};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_step     <= n_step;
        r_heading  <= n_heading;
        r_remote   <= n_remote;
        r_cmd      <= n_cmd;
        r_out_data <= n_out_data;
    end

    `MHSD_ASSERT_SAME(a_step_range, r_state == ST_ROT, r_step <= STEP_W'(CORDIC_STEPS - 1), "CORDIC step past the last one")
    `MHSD_ASSERT_SAME(a_stop_heading, r_out_valid && (r_out_data[1:0] == CMD_STOP), r_out_data[10:2] == 9'd0, "stop result with nonzero heading")
    `MHSD_ASSERT_NEXT(a_pop_busy, o_pop, r_state != ST_IDLE, "engine idle right after taking a job")

endmodule

// ===== src/motion_heading_steer_decider.sv =====
// Top level of the heading steer decider: configuration registers and stream ports.
//
// Each input beat carries a remote angle byte, an accelerometer z sample and a
// magnetometer x/y pair; each produces exactly one output beat with a steering
// command (stop, forward, left, right), the local heading in whole degrees and
// the decoded remote angle. The front end takes a beat in the cycle it is
// offered, as long as its two-entry job queue has room, decodes the remote
// angle, updates the three-sample z history and decides whether the unit is
// standing still. The heading engine behind the queue works on one job at a
// time: a still job goes straight to the output register, one whose
// magnetometer vector lies on an axis goes straight to the decision step,
// and any other runs the 16 CORDIC vectoring iterations that share a single
// add/shift stage, then the rounding, heading and decision steps, before the
// output register is loaded. The output register frees the engine as soon as
// a result is taken, and a new job is taken only after the last one's result
// is loaded. Registers sit on the APB-style port: turn tolerance at byte
// address 0 and still threshold at byte address 4 (only address bit 2 is
// decoded); write them only while the block is idle.
module motion_heading_steer_decider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // remote_angle_byte[7:0], accel_z[23:8],
                                        // mag_x[39:24], mag_y[55:40]
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // command[1:0], heading_deg[10:2],
                                        // remote_angle[20:11], zero[23:21]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mhsd_pkg::*;

    logic [7:0]  r_turn_tol;
    logic [15:0] r_still_thr;
    logic        w_cfg_write;
    logic        w_push;
    logic        w_full;
    logic        w_job_valid;
    logic        w_pop;
    t_job        w_front_job;
    t_job        w_queue_job;

    // Configuration registers. A write lands in the access phase.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_tol  <= 8'd25;
            r_still_thr <= 16'd100;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_TURN_TOL:  r_turn_tol  <= pwdata[7:0];
                REG_STILL_THR: r_still_thr <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TURN_TOL:  prdata = {24'd0, r_turn_tol};
            REG_STILL_THR: prdata = {16'd0, r_still_thr};
            default:       prdata = '0;
        endcase
    end

    // Front end: classifies each beat and hands a job to the queue.
    mhsd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_data            (s_axis_tdata),
        .i_still_threshold (r_still_thr),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_job             (w_front_job)
    );

    // Job queue decouples input acceptance from the heading engine.
    mhsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_job   (w_queue_job),
        .i_pop   (w_pop)
    );

    // Heading engine and output register.
    mhsd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (w_job_valid),
        .i_job            (w_queue_job),
        .o_pop            (w_pop),
        .i_turn_tolerance (r_turn_tol),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_data           (m_axis_tdata)
    );

endmodule
